// File: rtl/imu_fifo_batch_unpacker_unit_assert.svh
// assertion macros for the imu fifo batch unpacker
// used by rtl/imu_fifo_batch_unpacker_unit.sv, no other dependencies
`ifndef IMU_FIFO_BATCH_UNPACKER_UNIT_ASSERT_SVH
`define IMU_FIFO_BATCH_UNPACKER_UNIT_ASSERT_SVH

// same-cycle implication, disabled while reset is low
`define IFBU_ASSERT_NOW(name, clk, rst_n, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("ifbu assertion failed");

// next-cycle implication, disabled while reset is low
`define IFBU_ASSERT_NEXT(name, clk, rst_n, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error("ifbu assertion failed");

`endif

// File: rtl/ifbu_pkg.sv
// shared types, constants and helpers of the imu fifo batch unpacker
// no dependencies; used by ifbu_store and imu_fifo_batch_unpacker_unit
package ifbu_pkg;

  localparam int unsigned AXIS_W  = 16;
  localparam int unsigned TRIPLE_W = 3 * AXIS_W;
  localparam int unsigned REC_W   = 2 * TRIPLE_W;
  localparam int unsigned IDX_W   = 4;
  localparam int unsigned OUT_W   = 56;
  localparam int unsigned NRES_W  = 5;
  localparam logic [NRES_W-1:0] RESULT_CAP = 5'd24;

  typedef enum logic [1:0] {
    KIND_GYRO  = 2'd0,
    KIND_ACCEL = 2'd1,
    KIND_OVF   = 2'd2
  } kind_e;

  typedef enum logic [5:0] {
    ST_LOAD   = 6'b000001,
    ST_PH_RD  = 6'b000010,
    ST_PH_CMP = 6'b000100,
    ST_RD     = 6'b001000,
    ST_FORM   = 6'b010000,
    ST_OUT    = 6'b100000
  } state_e;

  // negate, with the most negative code saturating to the most positive
  function automatic logic [AXIS_W-1:0] neg_sat(input logic [AXIS_W-1:0] v);
    logic [AXIS_W-1:0] r;
    if (v == {1'b1, {(AXIS_W-1){1'b0}}}) begin
      r = {1'b0, {(AXIS_W-1){1'b1}}};
    end else begin
      r = {AXIS_W{1'b0}} - v;
    end
    return r;
  endfunction

endpackage

// File: rtl/ifbu_store.sv
// record store of the imu fifo batch unpacker: one write and one read port
// depends on ifbu_pkg for the record width
module ifbu_store import ifbu_pkg::*; #(
  parameter int unsigned DEPTH = 16,
  parameter int unsigned AW    = 4
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [REC_W-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [REC_W-1:0] rdata_o
);

  logic [REC_W-1:0] mem [DEPTH];
  logic [REC_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// File: rtl/imu_fifo_batch_unpacker_unit.sv
// imu fifo batch unpacker, top level
// depends on ifbu_pkg, ifbu_store and imu_fifo_batch_unpacker_unit_assert.svh
//
// Takes one fifo record per cycle while loading a batch. After the record
// with tlast, it emits all gyro samples of the batch, then the accel samples
// with the duplicate of each pair dropped, y and z negated with saturation.
// With four or more records the pair phase is found by walking records 0..3
// through a single 48-bit comparator. Each result then goes through store
// read, format and transfer, waiting out any output stall, all through
// the one read port of the record store. No input is taken from the last
// record of a batch until the final result of that batch is transferred.
// A batch longer than MAX_RECORDS gives a single overflow result. The store
// needs no clearing after reset.
module imu_fifo_batch_unpacker_unit import ifbu_pkg::*; #(
  parameter int unsigned MAX_RECORDS = 16
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             s_axis_tvalid,
  output logic             s_axis_tready,
  // accel_x, accel_y, accel_z, gyro_x, gyro_y, gyro_z
  input  logic [REC_W-1:0] s_axis_tdata,
  input  logic             s_axis_tlast,
  output logic             m_axis_tvalid,
  input  logic             m_axis_tready,
  // axis_x, axis_y, axis_z, sample_index, phase_error, zero pad
  output logic [OUT_W-1:0] m_axis_tdata,
  // kind
  output logic [1:0]       m_axis_tuser,
  output logic             m_axis_tlast
);

  localparam int unsigned AW = $clog2(MAX_RECORDS);
  localparam int unsigned CW = $clog2(MAX_RECORDS + 1);
  localparam int unsigned IW = CW + 1;
  localparam logic [CW-1:0] MAX_CNT = CW'(MAX_RECORDS);

  state_e              state_q, state_d;
  logic [CW-1:0]       cnt_q, cnt_d;
  logic                ovf_q, ovf_d;
  logic [1:0]          ph_q, ph_d;
  logic [1:0]          eq_q, eq_d;
  logic [TRIPLE_W-1:0] prev_q, prev_d;
  logic                first_q, first_d;
  logic                perr_q, perr_d;
  logic                gyro_q, gyro_d;
  logic [IW-1:0]       idx_q, idx_d;
  logic [IDX_W-1:0]    k_q, k_d;
  logic [NRES_W-1:0]   nres_q, nres_d;
  logic                m_valid_q, m_valid_d;
  logic [OUT_W-1:0]    m_data_q, m_data_d;
  logic [1:0]          m_user_q, m_user_d;
  logic                m_last_q, m_last_d;

  logic                in_xfer, out_xfer, full, we;
  logic [AW-1:0]       raddr;
  logic [REC_W-1:0]    rdata;
  logic [TRIPLE_W-1:0] sel;
  logic                eq_now, pat_a;
  logic [IW-1:0]       n_ext, idx_p1, idx_p2, first_ext;
  logic                is_last;
  logic [IDX_W-1:0]    sidx;

  assign s_axis_tready = (state_q == ST_LOAD);
  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;
  assign m_axis_tuser  = m_user_q;
  assign m_axis_tlast  = m_last_q;

  assign in_xfer  = s_axis_tvalid && s_axis_tready;
  assign out_xfer = m_valid_q && m_axis_tready;
  assign full     = (cnt_q == MAX_CNT);
  assign we       = in_xfer && !full;
  assign raddr    = (state_q == ST_PH_RD) ? AW'(ph_q) : idx_q[AW-1:0];

  ifbu_store #(
    .DEPTH (MAX_RECORDS),
    .AW    (AW)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (cnt_q[AW-1:0]),
    .wdata_i (s_axis_tdata),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  // shared compare unit: accel part of the record just read vs the one before
  assign eq_now = (rdata[TRIPLE_W-1:0] == prev_q);
  assign pat_a  = eq_q[0] && eq_now;

  assign n_ext     = IW'(cnt_q);
  assign idx_p1    = idx_q + IW'(1);
  assign idx_p2    = idx_q + IW'(2);
  assign first_ext = IW'(first_q);
  assign sel       = gyro_q ? rdata[REC_W-1:TRIPLE_W] : rdata[TRIPLE_W-1:0];
  assign sidx      = gyro_q ? idx_q[IDX_W-1:0] : k_q;

  always_comb begin
    if (nres_q == RESULT_CAP - NRES_W'(1)) begin
      is_last = 1'b1;
    end else if (gyro_q) begin
      is_last = (idx_p1 >= n_ext) && (first_ext >= n_ext);
    end else begin
      is_last = (idx_p2 >= n_ext);
    end
  end

  always_comb begin
    state_d   = state_q;
    cnt_d     = cnt_q;
    ovf_d     = ovf_q;
    ph_d      = ph_q;
    eq_d      = eq_q;
    prev_d    = prev_q;
    first_d   = first_q;
    perr_d    = perr_q;
    gyro_d    = gyro_q;
    idx_d     = idx_q;
    k_d       = k_q;
    nres_d    = nres_q;
    m_valid_d = m_valid_q;
    m_data_d  = m_data_q;
    m_user_d  = m_user_q;
    m_last_d  = m_last_q;

    unique case (state_q)
      ST_LOAD: begin
        if (in_xfer) begin
          if (full) begin
            ovf_d = 1'b1;
          end else begin
            cnt_d = cnt_q + CW'(1);
          end
          if (s_axis_tlast) begin
            gyro_d  = 1'b1;
            idx_d   = '0;
            k_d     = '0;
            nres_d  = '0;
            ph_d    = '0;
            first_d = 1'b1;
            perr_d  = 1'b0;
            if (full || ovf_q) begin
              m_valid_d = 1'b1;
              m_data_d  = '0;
              m_user_d  = KIND_OVF;
              m_last_d  = 1'b1;
              state_d   = ST_OUT;
            end else if (cnt_q >= CW'(3)) begin
              state_d = ST_PH_RD;
            end else begin
              state_d = ST_RD;
            end
          end
        end
      end

      ST_PH_RD: begin
        state_d = ST_PH_CMP;
      end

      ST_PH_CMP: begin
        prev_d = rdata[TRIPLE_W-1:0];
        unique case (ph_q)
          2'd0: ;
          2'd1: eq_d[0] = eq_now;
          2'd2: eq_d[1] = eq_now;
          2'd3: ;
          default: ;
        endcase
        if (ph_q == 2'd3) begin
          // pairs 0/1 and 2/3 win over 1/2, else fall back to phase 1
          first_d = pat_a || !eq_q[1];
          perr_d  = !pat_a && !eq_q[1];
          state_d = ST_RD;
        end else begin
          ph_d    = ph_q + 2'd1;
          state_d = ST_PH_RD;
        end
      end

      ST_RD: begin
        state_d = ST_FORM;
      end

      ST_FORM: begin
        m_valid_d = 1'b1;
        m_data_d  = {3'b000, perr_q, sidx,
                     neg_sat(sel[3*AXIS_W-1:2*AXIS_W]),
                     neg_sat(sel[2*AXIS_W-1:AXIS_W]),
                     sel[AXIS_W-1:0]};
        m_user_d  = gyro_q ? KIND_GYRO : KIND_ACCEL;
        m_last_d  = is_last;
        state_d   = ST_OUT;
      end

      ST_OUT: begin
        if (out_xfer) begin
          m_valid_d = 1'b0;
          if (m_last_q) begin
            cnt_d   = '0;
            ovf_d   = 1'b0;
            state_d = ST_LOAD;
          end else begin
            nres_d = nres_q + NRES_W'(1);
            if (!gyro_q) begin
              idx_d = idx_p2;
              k_d   = k_q + IDX_W'(1);
            end else if (idx_p1 < n_ext) begin
              idx_d = idx_p1;
            end else begin
              // gyro run done, start the accel run at the chosen phase
              gyro_d = 1'b0;
              idx_d  = first_ext;
              k_d    = '0;
            end
            state_d = ST_RD;
          end
        end
      end

      default: begin
        state_d = ST_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_LOAD;
      cnt_q     <= '0;
      ovf_q     <= 1'b0;
      ph_q      <= '0;
      gyro_q    <= 1'b1;
      idx_q     <= '0;
      k_q       <= '0;
      nres_q    <= '0;
      m_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      cnt_q     <= cnt_d;
      ovf_q     <= ovf_d;
      ph_q      <= ph_d;
      gyro_q    <= gyro_d;
      idx_q     <= idx_d;
      k_q       <= k_d;
      nres_q    <= nres_d;
      m_valid_q <= m_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    eq_q     <= eq_d;
    prev_q   <= prev_d;
    first_q  <= first_d;
    perr_q   <= perr_d;
    m_data_q <= m_data_d;
    m_user_q <= m_user_d;
    m_last_q <= m_last_d;
  end

`include "imu_fifo_batch_unpacker_unit_assert.svh"

  // loading and emitting never overlap
  `IFBU_ASSERT_NOW(a_no_overlap, clk_i, rst_ni, m_axis_tvalid, !s_axis_tready)
  // an overflow status is always the only and final result
  `IFBU_ASSERT_NOW(a_ovf_last, clk_i, rst_ni,
                   m_axis_tvalid && (m_axis_tuser == KIND_OVF), m_axis_tlast)
  // after the final transfer of a batch the block loads again
  `IFBU_ASSERT_NEXT(a_back_to_load, clk_i, rst_ni,
                    m_axis_tvalid && m_axis_tready && m_axis_tlast, s_axis_tready)
  // record count never passes the store depth
  `IFBU_ASSERT_NOW(a_cnt_range, clk_i, rst_ni, 1'b1, cnt_q <= MAX_CNT)

endmodule

// File: sim/imu_fifo_batch_unpacker_unit_tb.sv
// self-checking testbench for imu_fifo_batch_unpacker_unit
// depends on ifbu_pkg and the rtl of the unit; directed table, then random batches
module imu_fifo_batch_unpacker_unit_tb import ifbu_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int STORE_DEPTH = 16;
  localparam int HOLD_CYCLES = 300;

  typedef struct packed {
    logic [15:0] z;
    logic [15:0] y;
    logic [15:0] x;
  } triple_t;

  // accel in the low half, as on s_axis_tdata
  typedef struct packed {
    triple_t gyro;
    triple_t accel;
  } rec_t;

  typedef struct packed {
    kind_e       kind;
    logic [15:0] x;
    logic [15:0] y;
    logic [15:0] z;
    logic [3:0]  idx;
    logic        perr;
    logic        last;
  } sample_t;

  typedef struct {
    int      fill;
    rec_t    rec;
    bit      last;
    bit      typed;
    sample_t want;
  } step_t;

  // how the accel duplicates line up inside a random batch
  typedef enum int {DUP_EVEN, DUP_ODD, DUP_NONE, DUP_HEAD, DUP_ALL} dup_e;

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              s_axis_tvalid = 1'b0;
  logic              s_axis_tready;
  logic [REC_W-1:0]  s_axis_tdata = '0;
  logic              s_axis_tlast = 1'b0;
  logic              m_axis_tvalid;
  logic              m_axis_tready = 1'b0;
  logic [OUT_W-1:0]  m_axis_tdata;
  logic [1:0]        m_axis_tuser;
  logic              m_axis_tlast;

  rec_t    store [STORE_DEPTH];
  int      stored = 0;
  bit      spilled = 1'b0;
  sample_t fresh[$];
  sample_t sample_q[$];
  step_t   plan[$];
  int      faults = 0;
  bit      stall_rx = 1'b0;

  always #10 clk_i = ~clk_i;

  imu_fifo_batch_unpacker_unit #(.MAX_RECORDS(STORE_DEPTH)) dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tlast (s_axis_tlast),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .m_axis_tlast (m_axis_tlast)
  );

  function automatic logic [15:0] flip(input logic [15:0] v);
    if (v == 16'h8000) return 16'h7fff;
    return ~v + 16'd1;
  endfunction

  function automatic sample_t make_sample(input kind_e k, input triple_t t, input int idx,
                                          input bit perr, input bit last);
    sample_t s;
    s.kind = k;
    s.x    = t.x;
    s.y    = flip(t.y);
    s.z    = flip(t.z);
    s.idx  = idx[3:0];
    s.perr = perr;
    s.last = last;
    return s;
  endfunction

  // store one record; on the batch end, fill fresh with the samples it releases
  function automatic void take_record(input rec_t r, input bit last);
    int      n;
    int      start;
    int      total;
    int      made;
    int      k;
    bit      bad;
    sample_t s;
    fresh.delete();
    if (stored < STORE_DEPTH) begin
      store[stored] = r;
      stored++;
    end else begin
      spilled = 1'b1;
    end
    if (!last) return;
    if (spilled) begin
      s = '0;
      s.kind = KIND_OVF;
      s.last = 1'b1;
      fresh.push_back(s);
    end else begin
      n = stored;
      start = 1;
      bad = 1'b0;
      if (n >= 4) begin
        if (store[0].accel == store[1].accel && store[2].accel == store[3].accel) begin
          start = 1;
        end else if (store[1].accel == store[2].accel) begin
          start = 0;
        end else begin
          bad = 1'b1;
        end
      end
      total = n + ((n > start) ? (n - start + 1) / 2 : 0);
      made = 0;
      for (int i = 0; i < n; i++) begin
        made++;
        fresh.push_back(make_sample(KIND_GYRO, store[i].gyro, i, bad, made == total));
      end
      k = 0;
      for (int i = start; i < n; i += 2) begin
        made++;
        fresh.push_back(make_sample(KIND_ACCEL, store[i].accel, k, bad, made == total));
        k++;
      end
    end
    stored = 0;
    spilled = 1'b0;
  endfunction

  function automatic logic [15:0] rand_axis();
    case ($urandom_range(0, 7))
      0: return 16'h8000;
      1: return 16'h7fff;
      2: return 16'h0000;
      3: return 16'hffff;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic triple_t rand_triple();
    triple_t t;
    t.x = rand_axis();
    t.y = rand_axis();
    t.z = rand_axis();
    return t;
  endfunction

  function automatic rec_t pack_rec(input logic [15:0] ax, ay, az, gx, gy, gz);
    rec_t r;
    r.accel = '{z: az, y: ay, x: ax};
    r.gyro  = '{z: gz, y: gy, x: gx};
    return r;
  endfunction

  function automatic void add_row(input int fill, input logic [15:0] ax, ay, az, gx, gy, gz,
                                  input bit last, input bit typed, input kind_e k,
                                  input logic [15:0] ex, ey, ez);
    step_t st;
    st.fill  = fill;
    st.rec   = pack_rec(ax, ay, az, gx, gy, gz);
    st.last  = last;
    st.typed = typed;
    st.want  = '{kind: k, x: ex, y: ey, z: ez, idx: 4'd0, perr: 1'b0, last: 1'b1};
    plan.push_back(st);
  endfunction

  // offer one record after gap idle cycles; returns at the accepting edge
  task automatic send_record(input rec_t r, input bit last, input int gap,
                             input bit typed, input sample_t want);
    @(negedge clk_i);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= r;
    s_axis_tlast  <= last;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    take_record(r, last);
    if (typed) begin
      sample_q.push_back(want);
    end else begin
      foreach (fresh[i]) sample_q.push_back(fresh[i]);
    end
  endtask

  task automatic send_batch(input int n, input dup_e dup, input bit quiet);
    rec_t    r;
    triple_t a;
    for (int i = 0; i < n; i++) begin
      r.gyro = rand_triple();
      case (dup)
        DUP_EVEN: if (i % 2 == 0) a = rand_triple();
        DUP_ODD:  if (i == 0 || i % 2 == 1) a = rand_triple();
        DUP_HEAD: if (i != 1) a = rand_triple();
        DUP_ALL:  if (i == 0) a = rand_triple();
        default:  a = rand_triple();
      endcase
      r.accel = a;
      send_record(r, i == n - 1, quiet ? 0 : $urandom_range(0, 9), 1'b0, '0);
    end
  endtask

  task automatic drain();
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (sample_q.size() != 0) @(posedge clk_i);
  endtask

  function automatic void check_field(input string name, input int want, input int got);
    if (want != got) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      faults++;
    end
  endfunction

  always @(posedge clk_i) begin
    sample_t w;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (sample_q.size() == 0) begin
        $error("transfer with nothing expected: kind %0d", m_axis_tuser);
        faults++;
      end else begin
        w = sample_q.pop_front();
        check_field("kind", w.kind, m_axis_tuser);
        check_field("axis_x", w.x, m_axis_tdata[15:0]);
        check_field("axis_y", w.y, m_axis_tdata[31:16]);
        check_field("axis_z", w.z, m_axis_tdata[47:32]);
        check_field("sample_index", w.idx, m_axis_tdata[51:48]);
        check_field("phase_error", w.perr, m_axis_tdata[52]);
        check_field("last_result", w.last, m_axis_tlast);
      end
    end
  end

  // output side: random hold-off before every transfer, quiet every third stretch
  initial begin
    int gap;
    int taken;
    bit held;
    taken = 0;
    held = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      gap = ((taken / 30) % 3 == 2) ? 0 : $urandom_range(0, 9);
      if (stall_rx && !held) begin
        gap = HOLD_CYCLES;
        held = 1'b1;
      end
      if (gap > 0) begin
        m_axis_tready <= 1'b0;
        repeat (gap) @(negedge clk_i);
      end
      m_axis_tready <= 1'b1;
      @(posedge clk_i);
      while (!m_axis_tvalid) @(posedge clk_i);
      taken++;
    end
  end

  initial begin
    #2_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

  initial begin
    int   items;
    int   batch;
    int   n;
    int   pick;
    dup_e dup;
    rec_t r;
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // single records at the axis extremes, typed results
    add_row(0, 16'h1234, 16'h8000, 16'h7fff, 16'h8000, 16'h8000, 16'h7fff,
            1, 1, KIND_GYRO, 16'h8000, 16'h7fff, 16'h8001);
    add_row(0, 16'h0000, 16'h0000, 16'h0000, 16'h7fff, 16'h7fff, 16'h8000,
            1, 1, KIND_GYRO, 16'h7fff, 16'h8001, 16'h7fff);
    add_row(0, 16'hffff, 16'hffff, 16'hffff, 16'h0000, 16'hffff, 16'h0000,
            1, 1, KIND_GYRO, 16'h0000, 16'h0001, 16'h0000);
    // pairs on records 0/1 and 2/3
    add_row(0, 16'h8000, 16'h7fff, 16'h0000, 16'h0001, 16'h0002, 16'h0003, 0, 0, KIND_GYRO, 0, 0, 0);
    add_row(0, 16'h8000, 16'h7fff, 16'h0000, 16'hfff1, 16'h8000, 16'h7fff, 0, 0, KIND_GYRO, 0, 0, 0);
    add_row(0, 16'hffff, 16'h8000, 16'h0001, 16'h5555, 16'haaaa, 16'h0000, 0, 0, KIND_GYRO, 0, 0, 0);
    add_row(0, 16'hffff, 16'h8000, 16'h0001, 16'h0100, 16'hff00, 16'h8000, 1, 0, KIND_GYRO, 0, 0, 0);
    // pairs on records 1/2
    add_row(0, 16'h0011, 16'h0022, 16'h0033, 16'h1111, 16'h2222, 16'h3333, 0, 0, KIND_GYRO, 0, 0, 0);
    add_row(0, 16'h7fff, 16'h7fff, 16'h8000, 16'h4444, 16'h8000, 16'h6666, 0, 0, KIND_GYRO, 0, 0, 0);
    add_row(0, 16'h7fff, 16'h7fff, 16'h8000, 16'h7777, 16'h8888, 16'h9999, 0, 0, KIND_GYRO, 0, 0, 0);
    add_row(0, 16'h0044, 16'h0055, 16'h0066, 16'haaaa, 16'hbbbb, 16'hcccc, 1, 0, KIND_GYRO, 0, 0, 0);
    // no pattern: phase error on every sample
    add_row(0, 16'h0001, 16'h0001, 16'h0001, 16'h0101, 16'h0202, 16'h0303, 0, 0, KIND_GYRO, 0, 0, 0);
    add_row(0, 16'h0002, 16'h0001, 16'h0001, 16'h0404, 16'h0505, 16'h0606, 0, 0, KIND_GYRO, 0, 0, 0);
    add_row(0, 16'h0001, 16'h0002, 16'h0001, 16'h0707, 16'h0808, 16'h0909, 0, 0, KIND_GYRO, 0, 0, 0);
    add_row(0, 16'h0001, 16'h0001, 16'h0002, 16'h8000, 16'h8000, 16'h8000, 1, 0, KIND_GYRO, 0, 0, 0);
    // short batches keep phase 1 without a check
    add_row(0, 16'h0aaa, 16'h0bbb, 16'h0ccc, 16'h1000, 16'h2000, 16'h3000, 0, 0, KIND_GYRO, 0, 0, 0);
    add_row(0, 16'h0ddd, 16'h8000, 16'h0fff, 16'h4000, 16'h5000, 16'h6000, 0, 0, KIND_GYRO, 0, 0, 0);
    add_row(0, 16'h0aaa, 16'h0bbb, 16'h0ccc, 16'h7000, 16'h8000, 16'h9000, 1, 0, KIND_GYRO, 0, 0, 0);
    add_row(0, 16'h1357, 16'h2468, 16'h8000, 16'hffff, 16'hffff, 16'hffff, 0, 0, KIND_GYRO, 0, 0, 0);
    add_row(0, 16'h7531, 16'h8642, 16'h7fff, 16'h0000, 16'h0000, 16'h0000, 1, 0, KIND_GYRO, 0, 0, 0);
    // a full store plus one more record: overflow status only
    add_row(STORE_DEPTH, 16'h1111, 16'h2222, 16'h3333, 16'h4444, 16'h5555, 16'h6666,
            1, 1, KIND_OVF, 16'h0000, 16'h0000, 16'h0000);

    foreach (plan[i]) begin
      for (int j = 0; j < plan[i].fill; j++) begin
        r.accel = rand_triple();
        r.gyro  = rand_triple();
        send_record(r, 1'b0, $urandom_range(0, 9), 1'b0, '0);
      end
      send_record(plan[i].rec, plan[i].last, $urandom_range(0, 9), plan[i].typed, plan[i].want);
    end

    items = 0;
    batch = 0;
    while (items < 120) begin
      n = ($urandom_range(0, 7) == 0) ? $urandom_range(STORE_DEPTH + 1, STORE_DEPTH + 3)
                                       : $urandom_range(1, STORE_DEPTH);
      pick = $urandom_range(0, 9);
      if (pick < 4) dup = DUP_EVEN;
      else if (pick < 7) dup = DUP_ODD;
      else if (pick == 7) dup = DUP_NONE;
      else if (pick == 8) dup = DUP_HEAD;
      else dup = DUP_ALL;
      // output side holds off long while the next batch piles up behind it
      if (batch == 2) stall_rx = 1'b1;
      if (batch == 5 || batch == 9) drain();
      send_batch(n, dup, $urandom_range(0, 3) == 0);
      items += n;
      batch++;
    end

    drain();
    repeat (50) @(posedge clk_i);
    if (faults == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
